/* hdl/agvp_pkg.sv */
// shared types, constants and control program for the alternating gait velocity profile unit
// no dependencies; imported by agvp_seq, agvp_dp and the top level
package agvp_pkg;

  localparam int TABLE_LEN = 20;
  localparam int TIW       = $clog2(TABLE_LEN);
  localparam int PROG_LEN  = 10;
  localparam int PCW       = $clog2(PROG_LEN);

  localparam logic [15:0] CYCLE_LEN_RST  = 16'd1000;
  localparam logic [15:0] PEAK_SPEED_RST = 16'd10240;

  // operation codes of an input item
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_START  = 1'b1;

  // configuration register indexes
  localparam logic REG_CYCLE_LEN  = 1'b0;
  localparam logic REG_PEAK_SPEED = 1'b1;

  // leg and phase codes
  localparam logic [1:0] CODE_ONE = 2'd1;
  localparam logic [1:0] CODE_TWO = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [31:0] now_ms;
  } agvp_in_t;

  typedef struct packed {
    logic signed [16:0] drive_velocity;
    logic [1:0]         motor_one_phase;
    logic [1:0]         motor_two_phase;
    logic [1:0]         lifting_leg;
  } agvp_out_t;

  typedef enum logic [3:0] {
    A_NOP      = 4'd0,
    A_FETCH    = 4'd1,
    A_START    = 4'd2,
    A_ELAPSED  = 4'd3,
    A_WRAP     = 4'd4,
    A_DIV_LOAD = 4'd5,
    A_DIV      = 4'd6,
    A_LOOKUP   = 4'd7,
    A_MUL      = 4'd8,
    A_EMIT     = 4'd9
  } agvp_act_t;

  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NO_INPUT = 3'd2,
    C_START    = 3'd3,
    C_LEN_ZERO = 3'd4,
    C_DIV_MORE = 3'd5,
    C_OUT_BUSY = 3'd6
  } agvp_cond_t;

  typedef struct packed {
    agvp_act_t        act;
    agvp_cond_t       cond;
    logic [PCW-1:0]   target;
  } agvp_word_t;

  typedef struct packed {
    logic no_input;
    logic is_start;
    logic len_zero;
    logic div_more;
    logic out_busy;
  } agvp_stat_t;

  // control program: jump to target when the condition holds, else fall through
  function automatic agvp_word_t agvp_rom(input logic [PCW-1:0] pc);
    agvp_word_t w;
    case (pc)
      PCW'(0): w = '{A_FETCH,    C_NO_INPUT, PCW'(0)};
      PCW'(1): w = '{A_START,    C_START,    PCW'(0)};
      PCW'(2): w = '{A_ELAPSED,  C_NEVER,    PCW'(0)};
      PCW'(3): w = '{A_WRAP,     C_NEVER,    PCW'(0)};
      PCW'(4): w = '{A_DIV_LOAD, C_LEN_ZERO, PCW'(6)};
      PCW'(5): w = '{A_DIV,      C_DIV_MORE, PCW'(5)};
      PCW'(6): w = '{A_LOOKUP,   C_NEVER,    PCW'(0)};
      PCW'(7): w = '{A_MUL,      C_NEVER,    PCW'(0)};
      PCW'(8): w = '{A_EMIT,     C_OUT_BUSY, PCW'(8)};
      PCW'(9): w = '{A_NOP,      C_ALWAYS,   PCW'(0)};
      default: w = '{A_NOP,      C_ALWAYS,   PCW'(0)};
    endcase
    return w;
  endfunction

  // normalized velocity curve, unsigned Q0.16
  function automatic logic [15:0] agvp_curve(input logic [TIW-1:0] idx);
    logic [15:0] v;
    case (idx)
      TIW'(0):  v = 16'd20840;
      TIW'(1):  v = 16'd46989;
      TIW'(2):  v = 16'd62456;
      TIW'(3):  v = 16'd58917;
      TIW'(4):  v = 16'd49938;
      TIW'(5):  v = 16'd38011;
      TIW'(6):  v = 16'd28770;
      TIW'(7):  v = 16'd24576;
      TIW'(8):  v = 16'd24510;
      TIW'(9):  v = 16'd27132;
      TIW'(10): v = 16'd28836;
      TIW'(11): v = 16'd27525;
      TIW'(12): v = 16'd23462;
      TIW'(13): v = 16'd18285;
      TIW'(14): v = 16'd14221;
      TIW'(15): v = 16'd11534;
      TIW'(16): v = 16'd10551;
      TIW'(17): v = 16'd9830;
      TIW'(18): v = 16'd7602;
      TIW'(19): v = 16'd4194;
      default:  v = 16'd4194;
    endcase
    return v;
  endfunction

endpackage

/* hdl/alternating_gait_velocity_profile_unit.sv */
// top level of the alternating gait velocity profile unit
// depends on agvp_pkg, agvp_seq and agvp_dp
//
// Start items end after the start step; update items go on through the
// elapsed, wrap, divide, lookup, multiply and emit steps (the divide steps
// are skipped when the cycle length is zero); the emit step waits while the
// output register is still full. They follow a ten-step control program in
// which the curve index comes from a restoring divider that resolves one
// quotient bit per cycle. A finished result waits in the output register while
// the next item is taken in. Config writes are always ready and apply at once;
// write them only while idle.
module alternating_gait_velocity_profile_unit import agvp_pkg::*; #(
  parameter int CURVE_POINTS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  agvp_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output agvp_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  agvp_word_t word;
  agvp_stat_t stat;

  agvp_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .word (word)
  );

  agvp_dp #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .word      (word),
    .stat      (stat),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

/* hdl/agvp_seq.sv */
// microcode sequencer: step counter, program table lookup and conditional jumps
// depends on agvp_pkg
module agvp_seq import agvp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  agvp_stat_t stat,
  output agvp_word_t word
);

  logic [PCW-1:0] pc;
  logic [PCW-1:0] pc_next;
  logic           jump;

  assign word = agvp_rom(pc);

  always_comb begin
    case (word.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_INPUT: jump = stat.no_input;
      C_START:    jump = stat.is_start;
      C_LEN_ZERO: jump = stat.len_zero;
      C_DIV_MORE: jump = stat.div_more;
      C_OUT_BUSY: jump = stat.out_busy;
      default:    jump = 1'b1;
    endcase
    pc_next = jump ? word.target : pc + PCW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

`ifndef SYNTHESIS
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    32'(pc) < PROG_LEN)
    else $error("step counter outside the program");

  a_jump_taken: assert property (@(posedge clk) disable iff (rst)
    jump |=> pc == $past(word.target))
    else $error("conditional jump did not reach its target");
`endif

endmodule

/* hdl/agvp_dp.sv */
// datapath: config registers, cycle state, restoring divider, curve lookup,
// scaling multiplier and output register; depends on agvp_pkg
module agvp_dp import agvp_pkg::*; #(
  parameter int CURVE_POINTS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  agvp_word_t word,
  output agvp_stat_t stat,
  input  logic       in_valid,
  output logic       in_ready,
  input  agvp_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output agvp_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int QW = $clog2(CURVE_POINTS);
  localparam int DW = 16 + QW;
  localparam int CW = ((QW > TIW) ? QW : TIW) + 1;
  localparam logic [CW-1:0] PTS_LAST = CW'(CURVE_POINTS - 1);
  localparam logic [CW-1:0] TAB_LAST = CW'(TABLE_LEN - 1);

  logic [15:0]   cycle_len;
  logic [15:0]   peak_speed;
  logic [31:0]   origin;
  logic          leg_two;
  logic          op;
  logic [31:0]   now_r;
  logic [31:0]   elapsed;
  logic [DW-1:0] rem;
  logic [QW-1:0] q;
  logic [QW-1:0] cnt;
  logic [15:0]   curve;
  logic [31:0]   prod;

  logic [DW-1:0] div_shift;
  logic [CW-1:0] qx;
  logic [CW-1:0] idx;
  logic [32:0]   rounded;
  logic [16:0]   mag;
  logic          emit;

  assign in_ready  = (word.act == A_FETCH);
  assign cfg_ready = 1'b1;

  assign stat.no_input = !in_valid;
  assign stat.is_start = (op == OP_START);
  assign stat.len_zero = (cycle_len == 16'd0);
  assign stat.div_more = (cnt != '0);
  assign stat.out_busy = out_valid && !out_ready;

  assign emit = (word.act == A_EMIT) && !stat.out_busy;

  always_comb begin
    div_shift = DW'(cycle_len) << cnt;
    qx = CW'(q);
    idx = qx;
    if (idx > PTS_LAST) begin
      idx = PTS_LAST;
    end
    if (idx > TAB_LAST) begin
      idx = TAB_LAST;
    end
    // round half up back to q8.8
    rounded = 33'(prod) + 33'd32768;
    mag = rounded[32:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_len  <= CYCLE_LEN_RST;
      peak_speed <= PEAK_SPEED_RST;
      origin     <= '0;
      leg_two    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CYCLE_LEN:  cycle_len  <= cfg_data;
          REG_PEAK_SPEED: peak_speed <= cfg_data;
          default: ;
        endcase
      end
      // a new item may replace the one taken in the same cycle
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (word.act)
        A_START: begin
          if (op == OP_START) begin
            origin  <= now_r;
            leg_two <= 1'b0;
          end
        end
        A_WRAP: begin
          if (elapsed >= 32'(cycle_len)) begin
            leg_two <= !leg_two;
            origin  <= now_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op    <= in_data.operation;
      now_r <= in_data.now_ms;
    end
    case (word.act)
      A_ELAPSED: elapsed <= now_r - origin;
      A_WRAP: begin
        if (elapsed >= 32'(cycle_len)) begin
          elapsed <= '0;
        end
      end
      A_DIV_LOAD: begin
        rem <= DW'(elapsed[15:0]) * DW'(CURVE_POINTS);
        q   <= '0;
        cnt <= QW'(QW - 1);
      end
      A_DIV: begin
        // one quotient bit per step, msb first
        if (rem >= div_shift) begin
          rem <= rem - div_shift;
          q   <= q | (QW'(1) << cnt);
        end
        if (cnt != '0) begin
          cnt <= cnt - QW'(1);
        end
      end
      A_LOOKUP: curve <= agvp_curve(idx[TIW-1:0]);
      A_MUL:    prod  <= 32'(curve) * 32'(peak_speed);
      default: ;
    endcase
    if (emit) begin
      out_data.drive_velocity  <= leg_two ? $signed(17'd0 - mag) : $signed(mag);
      out_data.motor_one_phase <= leg_two ? CODE_TWO : CODE_ONE;
      out_data.motor_two_phase <= leg_two ? CODE_ONE : CODE_TWO;
      out_data.lifting_leg     <= leg_two ? CODE_TWO : CODE_ONE;
    end
  end

`ifndef SYNTHESIS
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    (word.act == A_LOOKUP) |-> (CW'(q) < CW'(CURVE_POINTS)))
    else $error("curve index quotient beyond the point count");

  a_start_resets: assert property (@(posedge clk) disable iff (rst)
    (word.act == A_START && op == OP_START) |=> (!leg_two && origin == $past(now_r)))
    else $error("start item did not restart the cycle on leg one");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// testbench for the alternating gait velocity profile unit: drives timed start and update items,
// predicts every velocity result in its own model and checks it; depends on agvp_pkg and the top level
module tb import agvp_pkg::*; ();

  localparam int CURVE_POINTS  = 20;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 500000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  agvp_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  agvp_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  alternating_gait_velocity_profile_unit #(
    .CURVE_POINTS(CURVE_POINTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // normalized lift curve in Q0.16
  logic [15:0] gait_curve [20] = '{
    16'd20840, 16'd46989, 16'd62456, 16'd58917, 16'd49938,
    16'd38011, 16'd28770, 16'd24576, 16'd24510, 16'd27132,
    16'd28836, 16'd27525, 16'd23462, 16'd18285, 16'd14221,
    16'd11534, 16'd10551, 16'd9830,  16'd7602,  16'd4194
  };

  // predicted state and registers
  logic [31:0] origin_ms  = '0;
  logic        leg_two    = 1'b0;
  logic [15:0] cycle_len  = CYCLE_LEN_RST;
  logic [15:0] peak_speed = PEAK_SPEED_RST;

  agvp_out_t gait_results_q [$];
  int        errors       = 0;
  int        cycle_count  = 0;
  bit        idling       = 1'b1;
  bit        hold_request = 1'b0;

  function automatic bit predict_gait(input agvp_in_t item, output agvp_out_t res);
    logic [31:0] elapsed;
    logic [63:0] point;
    logic [63:0] prod;
    logic [16:0] mag;
    res = '0;
    if (item.operation == OP_START) begin
      origin_ms = item.now_ms;
      leg_two   = 1'b0;
      return 1'b0;
    end
    elapsed = item.now_ms - origin_ms;
    if (elapsed >= 32'(cycle_len)) begin
      leg_two   = ~leg_two;
      origin_ms = item.now_ms;
      elapsed   = '0;
    end
    if (cycle_len == 16'd0) begin
      point = '0;
    end else begin
      point = (64'(elapsed) * 64'(CURVE_POINTS)) / 64'(cycle_len);
    end
    if (point >= 64'(CURVE_POINTS)) point = 64'(CURVE_POINTS - 1);
    if (point >= 64'd20) point = 64'd19;
    prod = 64'(gait_curve[point]) * 64'(peak_speed) + 64'd32768;
    mag  = prod[32:16];
    if (leg_two) begin
      res.drive_velocity  = 17'd0 - mag;
      res.motor_one_phase = CODE_TWO;
      res.motor_two_phase = CODE_ONE;
      res.lifting_leg     = CODE_TWO;
    end else begin
      res.drive_velocity  = mag;
      res.motor_one_phase = CODE_ONE;
      res.motor_two_phase = CODE_TWO;
      res.lifting_leg     = CODE_ONE;
    end
    return 1'b1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("alternating_gait_velocity_profile_unit: mismatch");
      $finish;
    end
  end

  // valid stays high after acceptance so back-to-back items never drop it
  task automatic send_item(input agvp_in_t item);
    agvp_out_t res;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_gait(item, res)) gait_results_q.push_back(res);
  endtask

  task automatic send_update(input logic [31:0] t);
    send_item('{operation: OP_UPDATE, now_ms: t});
  endtask

  task automatic send_start(input logic [31:0] t);
    send_item('{operation: OP_START, now_ms: t});
  endtask

  // only while idle: drain results, let a trailing start item finish
  task automatic write_reg(input logic idx, input logic [15:0] value);
    in_valid <= 1'b0;
    while (gait_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_CYCLE_LEN) cycle_len = value;
    else peak_speed = value;
  endtask

  task automatic check_field(input string name, input logic [16:0] want, input logic [16:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    agvp_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (gait_results_q.size() == 0) begin
        $display("%0t: no result expected, actual %p", $time, out_data);
        errors++;
      end else begin
        want = gait_results_q.pop_front();
        check_field("drive_velocity", want.drive_velocity, out_data.drive_velocity);
        check_field("motor_one_phase", 17'(want.motor_one_phase), 17'(out_data.motor_one_phase));
        check_field("motor_two_phase", 17'(want.motor_two_phase), 17'(out_data.motor_two_phase));
        check_field("lifting_leg", 17'(want.lifting_leg), 17'(out_data.lifting_leg));
      end
    end
  end

  // receiver: random stalls, a long hold-off on request, none in the quiet tail
  initial begin : result_sink
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else if (idling && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // reset values, curve edges, leg toggle and time wrap
  task automatic test_default_cycle;
    send_update(32'd0);
    send_update(32'd49);
    send_update(32'd50);
    send_update(32'd999);
    send_update(32'd1000);        // cycle done, leg two lifts
    send_update(32'd1500);
    send_update(32'd500);         // earlier than origin: wraps, toggles back
    send_start(32'hFFFF_FFF0);
    send_update(32'h0000_0010);   // elapsed crosses zero
    send_update(32'hFFFF_FFFF);
  endtask

  task automatic test_register_extremes;
    write_reg(REG_CYCLE_LEN, 16'd0);
    write_reg(REG_PEAK_SPEED, 16'hFFFF);
    // zero length: every update toggles
    send_update(32'h1234_5678);
    send_update(32'h1234_5678);
    send_start(32'd0);
    send_update(32'd0);
    write_reg(REG_CYCLE_LEN, 16'hFFFF);
    write_reg(REG_PEAK_SPEED, 16'd0);
    send_start(32'h8000_0000);
    send_update(32'h8000_FFFE);
    send_update(32'h8000_FFFF);
    write_reg(REG_CYCLE_LEN, 16'd1);
    write_reg(REG_PEAK_SPEED, 16'hFFFF);
    send_start(32'd5);
    send_update(32'd5);
    send_update(32'd6);
  endtask

  // mostly steadily advancing time from a start, with restarts and stray times mixed in
  task automatic test_gait_phase(input logic [15:0] len, input logic [15:0] peak, input int count);
    logic [31:0] t;
    int sent;
    int roll;
    write_reg(REG_CYCLE_LEN, len);
    write_reg(REG_PEAK_SPEED, peak);
    t = $urandom;
    send_start(t);
    for (sent = 1; sent < count; sent++) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        t = $urandom;
        send_start(t);
      end else if (roll < 10) begin
        send_update($urandom);
      end else begin
        if (roll < 16) t = t + 32'(len);
        else t = t + $urandom_range(0, int'(len) / 6 + 1);
        send_update(t);
      end
    end
  endtask

  task automatic test_output_stall;
    logic [31:0] t;
    int k;
    write_reg(REG_CYCLE_LEN, CYCLE_LEN_RST);
    write_reg(REG_PEAK_SPEED, PEAK_SPEED_RST);
    t = $urandom;
    send_start(t);
    hold_request = 1'b1;
    for (k = 0; k < 40; k++) begin
      t = t + $urandom_range(0, 200);
      send_update(t);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_CYCLE_LEN;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_cycle;
    test_register_extremes;
    test_gait_phase(CYCLE_LEN_RST, PEAK_SPEED_RST, 170);
    test_gait_phase(16'd1, 16'hFFFF, 120);
    test_gait_phase(16'hFFFF, 16'd0, 120);
    test_gait_phase(16'd0, 16'($urandom), 60);
    test_gait_phase(16'($urandom_range(2, 5000)), 16'($urandom), 220);
    test_gait_phase(16'($urandom_range(2, 65535)), 16'($urandom), 220);
    test_output_stall;
    idling = 1'b0;
    test_gait_phase(16'($urandom_range(2, 3000)), 16'($urandom), 150);

    in_valid <= 1'b0;
    while (gait_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("alternating_gait_velocity_profile_unit: match");
    end else begin
      $display("alternating_gait_velocity_profile_unit: mismatch");
    end
    $finish;
  end

endmodule
